// ----- sv/escape_run_length_decoder_macros.svh -----
// Assertion helpers shared by the decoder modules.
`ifndef ESCAPE_RUN_LENGTH_DECODER_MACROS_SVH
`define ESCAPE_RUN_LENGTH_DECODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ERLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ERLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/erld_pkg.sv -----
`default_nettype none

package erld_pkg;

  // Width of the decoded output offset counter.
  localparam int PositionBits = 24;
  localparam int FieldPosW = 24;

  localparam logic [7:0] EscLong = 8'hC0;
  localparam logic [7:0] ShortMask = 8'h3F;

  localparam logic KindRun = 1'b0;
  localparam logic KindEnd = 1'b1;

  // Parser phase codes.
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhLongLo = 3'd1;
  localparam logic [2:0] PhLongHi = 3'd2;
  localparam logic [2:0] PhLongVal = 3'd3;
  localparam logic [2:0] PhShortVal = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last_byte;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [7:0] run_value;
    logic [15:0] run_length;
    logic [23:0] run_start;
    logic [23:0] total_length;
    logic is_last;
  } result_t;

  // Results produced by one accepted byte: an optional run, an optional end.
  typedef struct packed {
    logic run_en;
    logic end_en;
    result_t run;
    result_t fin;
  } push_t;

  // Map the offset counter onto the 24-bit result fields.
  function automatic logic [FieldPosW-1:0] to_field(input logic [PositionBits-1:0] off);
    logic [31:0] wide;
    wide = 32'(off);
    return wide[FieldPosW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/erld_parser.sv -----
`default_nettype none

module erld_parser
  import erld_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire in_item_t item,
  output push_t         push
);

  `include "escape_run_length_decoder_macros.svh"

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [15:0] count;
  logic [15:0] count_next;
  logic [PositionBits-1:0] offset;
  logic [PositionBits-1:0] offset_next;
  logic [PositionBits-1:0] offset_run;
  logic run_en;
  logic [15:0] run_len;

  // Decode one byte against the current phase.
  always_comb begin
    phase_next = PhIdle;
    count_next = count;
    run_en = 1'b0;
    run_len = 16'd1;
    unique case (phase)
      PhLongLo: begin
        count_next = {8'd0, item.data_byte};
        phase_next = PhLongHi;
      end
      PhLongHi: begin
        count_next = {item.data_byte, count[7:0]};
        phase_next = PhLongVal;
      end
      PhLongVal, PhShortVal: begin
        run_len = count;
        run_en = (count != 16'd0);
        count_next = 16'd0;
        phase_next = PhIdle;
      end
      default: begin
        if (item.data_byte == EscLong) begin
          count_next = 16'd0;
          phase_next = PhLongLo;
        end else if (item.data_byte > EscLong) begin
          count_next = {8'd0, item.data_byte & ShortMask};
          phase_next = PhShortVal;
        end else begin
          run_en = 1'b1;
          run_len = 16'd1;
          phase_next = PhIdle;
        end
      end
    endcase
    offset_run = run_en ? offset + PositionBits'(run_len) : offset;
    offset_next = offset_run;
    // Return to a fresh block after the final byte.
    if (item.last_byte) begin
      phase_next = PhIdle;
      count_next = 16'd0;
      offset_next = '0;
    end
  end

  // Build the result items for the queue.
  always_comb begin
    push.run_en = run_en;
    push.end_en = item.last_byte;
    push.run.kind = KindRun;
    push.run.run_value = item.data_byte;
    push.run.run_length = run_len;
    push.run.run_start = to_field(offset);
    push.run.total_length = '0;
    push.run.is_last = 1'b0;
    push.fin.kind = KindEnd;
    push.fin.run_value = '0;
    push.fin.run_length = '0;
    push.fin.run_start = '0;
    push.fin.total_length = to_field(offset_run);
    push.fin.is_last = 1'b1;
  end

  // Advance parse state on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhIdle;
      count <= 16'd0;
      offset <= '0;
    end else if (fire) begin
      phase <= phase_next;
      count <= count_next;
      offset <= offset_next;
    end
  end

  `ERLD_ASSERT(a_phase_legal, phase <= PhShortVal, "parser phase left the legal range")
  `ERLD_ASSERT_NEXT(a_last_resets, fire && item.last_byte, phase == PhIdle && offset == '0 && count == 16'd0, "state not cleared after last byte")

endmodule

`default_nettype wire

// ----- sv/erld_out_queue.sv -----
`default_nettype none

module erld_out_queue
  import erld_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire push_t   push,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  `include "escape_run_length_decoder_macros.svh"

  localparam int Depth = 4;
  localparam int PtrW = $clog2(Depth);

  result_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0] count;
  logic [PtrW-1:0] end_ptr;
  logic [PtrW:0] n_push;
  logic pop;
  logic push_run;
  logic push_end;

  assign push_run = fire && push.run_en;
  assign push_end = fire && push.end_en;
  assign n_push = (PtrW+1)'(push_run) + (PtrW+1)'(push_end);
  assign end_ptr = wr_ptr + PtrW'(push_run);
  assign pop = out_valid && out_ready;

  // Accept a byte only while two entries are free.
  assign room = (count <= (PtrW+1)'(Depth - 2));
  assign out_valid = (count != '0);
  assign out_data = mem[rd_ptr];

  // Store the run result first, then the end result.
  always_ff @(posedge clk) begin
    if (push_run) begin
      mem[wr_ptr] <= push.run;
    end
    if (push_end) begin
      mem[end_ptr] <= push.fin;
    end
  end

  // Track pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + n_push - (PtrW+1)'(pop);
    end
  end

  `ERLD_ASSERT(a_no_overflow, count <= (PtrW+1)'(Depth), "result queue overflow")
  `ERLD_ASSERT(a_full_stalls, !room |-> !push_run && !push_end, "push while queue short of room")

endmodule

`default_nettype wire

// ----- sv/escape_run_length_decoder.sv -----
// Results are registered in a four-entry result queue before they are offered.
// Throughput: one byte per cycle; a byte can yield two results, which drain at one
// per cycle while out_ready is high; the queue stalls input when under two free.
// Reset (rst, synchronous): parser returns to idle with zero count and offset,
// and the result queue empties.
`default_nettype none

module escape_run_length_decoder
  import erld_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output result_t       out_data
);

  logic fire;
  push_t push;

  assign fire = in_valid && in_ready;

  erld_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_data),
    .push (push)
  );

  erld_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
